### design/cca_pkg.sv
// cca_pkg: constants, codes and shared types for the correlator X stage.
// No dependencies; imported by the interfaces and every module of the block.
`default_nettype none

package cca_pkg;

  // Array sizes
  localparam int MaxAntennas  = 8;
  localparam int MaxChannels  = 1024;
  localparam int NumProducts  = 4;
  localparam int NumBaselines = MaxAntennas * (MaxAntennas - 1) / 2;
  localparam int AccDepth     = NumBaselines * NumProducts * MaxChannels;

  // Field widths
  localparam int AntW     = 3;
  localparam int ChanW    = 10;
  localparam int BaseW    = 5;
  localparam int ProdW    = 2;
  localparam int SampW    = 16;
  localparam int AccW     = 48;
  localparam int VisW     = 33;
  localparam int CountW   = 16;
  localparam int CfgAntW  = 4;
  localparam int CfgChanW = 11;
  localparam int CfgDataW = 11;
  localparam int AddrW    = BaseW + ProdW + ChanW;

  // Command codes
  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdRead  = 2'd1,
    CmdClear = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam logic CfgAntennas = 1'b0;
  localparam logic CfgChannels = 1'b1;

  // Divider request and status
  typedef struct packed {
    logic              start;
    logic [AccW-1:0]   dividend;
    logic [CountW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

### design/cca_if.sv
// cca_in_if and cca_out_if: valid/ready channels of the correlator X stage.
// Depends on cca_pkg for field widths.
`default_nettype none

interface cca_in_if;
  import cca_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd;
  logic [AntW-1:0]         antenna;
  logic [ChanW-1:0]        channel;
  logic                    ant_ok;
  logic signed [SampW-1:0] pol_a_re;
  logic signed [SampW-1:0] pol_a_im;
  logic signed [SampW-1:0] pol_b_re;
  logic signed [SampW-1:0] pol_b_im;
  logic [BaseW-1:0]        baseline;
  logic [ProdW-1:0]        product;

  modport source (output valid, cmd, antenna, channel, ant_ok, pol_a_re, pol_a_im,
                  pol_b_re, pol_b_im, baseline, product, input ready);
  modport sink (input valid, cmd, antenna, channel, ant_ok, pol_a_re, pol_a_im,
                pol_b_re, pol_b_im, baseline, product, output ready);
endinterface

interface cca_out_if;
  import cca_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [VisW-1:0]   vis_re;
  logic signed [VisW-1:0]   vis_im;
  logic [CountW-1:0]        frame_count;

  modport source (output valid, vis_re, vis_im, frame_count, input ready);
  modport sink (input valid, vis_re, vis_im, frame_count, output ready);
endinterface

`default_nettype wire

### design/cross_correlation_accumulator.sv
// cross_correlation_accumulator: correlator X stage top level.
// Depends on cca_pkg, cca_if, cca_acc_ram and cca_div.
//
//   channel  | dir | payload
//   in_i     | in  | cmd, antenna, channel, ant_ok, pol_a/b_re/im, baseline, product
//   out_o    | out | vis_re, vis_im, frame_count
//   cfg      | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// A valid load of antenna k runs 4*k multiply-accumulate steps (one accumulator
// read-modify-write per cycle), then drains pipeline stages s1 and s2 before the
// next transaction is taken; other loads run no steps.
// A read runs through SRdAddr, SRdData, the 48-step divider (SRdDiv) and SRdOut,
// where it waits for out_o to be free; the next transaction can follow in the same
// cycle as the result appears. After reset and after clear a pass zeroes the whole
// accumulator memory, one entry per cycle, during which no transaction is taken.
// A result waiting on out_o does not block loads; a read waits for the slot.
`default_nettype none

module cross_correlation_accumulator import cca_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  cca_in_if.sink              in_i,
  cca_out_if.source           out_o
);

  typedef enum logic [2:0] {
    SSweep, SIdle, SMac, SRdAddr, SRdData, SRdDiv, SRdOut
  } state_e;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [VisW-1:0]   SatMag   = VisW'(64'h8000_0000);

  state_e state_q;

  logic [CfgAntW-1:0]  ants_q;
  logic [CfgChanW-1:0] chans_q;
  logic [CfgAntW-1:0]  na;
  logic [CfgChanW-1:0] nc;

  logic signed [SampW-1:0] samp_q [MaxAntennas][4];
  logic [MaxAntennas-1:0]  flags_q;
  logic [CountW-1:0]       frames_q [NumBaselines];

  logic [AntW-1:0]         k_q, j_q;
  logic [ProdW-1:0]        p_q;
  logic [ChanW-1:0]        ch_q;
  logic                    last_ch_q;
  logic signed [SampW-1:0] cur_q [4];
  logic [BaseW-1:0]        rd_b_q;
  logic [ProdW-1:0]        rd_p_q;
  logic [ChanW-1:0]        rd_ch_q;
  logic [AddrW-1:0]        sweep_q;
  logic                    neg_re_q, neg_im_q, zero_q;
  logic [CountW-1:0]       cnt_q;

  logic                    s1_v_q, s2_v_q;
  logic [AddrW-1:0]        s1_addr_q, s2_addr_q;
  logic signed [SampW-1:0] s1_ar_q, s1_ai_q, s1_cr_q, s1_ci_q;
  logic signed [2*SampW-1:0] s2_rr_q, s2_ii_q, s2_ir_q, s2_ri_q;
  logic [2*AccW-1:0]       s2_rd_q;

  logic                    accept;
  logic [BaseW-1:0]        mac_b;
  logic                    op_v;
  logic [AddrW-1:0]        raddr, waddr;
  logic                    we;
  logic [2*AccW-1:0]       wdata, rdata;
  logic signed [2*SampW:0] pr, pi;
  logic [AccW-1:0]         acc_re, acc_im;
  logic [CountW-1:0]       rd_cnt;
  div_req_t                req_re, req_im;
  div_sts_t                sts_re, sts_im;
  logic [AccW-1:0]         quot_re, quot_im;
  logic                    out_free;

  // baseline number of pair (j, k) for na antennas in use
  function automatic logic [BaseW-1:0] baseline_of(logic [AntW-1:0] j,
                                                   logic [AntW-1:0] k,
                                                   logic [CfgAntW-1:0] a);
    logic [7:0] jj;
    logic [7:0] v;
    begin
      jj = {5'd0, j};
      v  = jj * {4'd0, a} - ((jj * (jj + 8'd1)) >> 1) + {5'd0, k} - jj - 8'd1;
      return v[BaseW-1:0];
    end
  endfunction

  // saturate a quotient magnitude to 2^31 and apply the sign
  function automatic logic [VisW-1:0] to_vis(logic neg, logic [AccW-1:0] q);
    logic [VisW-1:0] mag;
    begin
      mag = (q > AccW'(SatMag)) ? SatMag : q[VisW-1:0];
      return neg ? VisW'(-mag) : mag;
    end
  endfunction

  // clamp configuration to its legal range
  always_comb begin
    na = ants_q;
    if (ants_q < CfgAntW'(2)) na = CfgAntW'(2);
    if (ants_q > CfgAntW'(MaxAntennas)) na = CfgAntW'(MaxAntennas);
    nc = chans_q;
    if (chans_q == '0) nc = CfgChanW'(1);
    if (chans_q > CfgChanW'(MaxChannels)) nc = CfgChanW'(MaxChannels);
  end

  assign in_i.ready = (state_q == SIdle) && !s1_v_q && !s2_v_q;
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_o.valid || out_o.ready;

  // current multiply-accumulate operation
  assign mac_b = baseline_of(j_q, k_q, na);
  assign op_v  = (state_q == SMac) && flags_q[j_q] && (mac_b < BaseW'(NumBaselines));

  // memory ports
  assign raddr = (state_q == SMac) ? {mac_b, p_q, ch_q} : {rd_b_q, rd_p_q, rd_ch_q};
  assign pr    = (2*SampW+1)'(s2_rr_q) + (2*SampW+1)'(s2_ii_q);
  assign pi    = (2*SampW+1)'(s2_ir_q) - (2*SampW+1)'(s2_ri_q);
  always_comb begin
    if (state_q == SSweep) begin
      we    = 1'b1;
      waddr = sweep_q;
      wdata = '0;
    end else begin
      we    = s2_v_q;
      waddr = s2_addr_q;
      wdata = {s2_rd_q[2*AccW-1:AccW] + AccW'(pi), s2_rd_q[AccW-1:0] + AccW'(pr)};
    end
  end

  cca_acc_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // divider requests, launched when read data arrives
  assign acc_re = rdata[AccW-1:0];
  assign acc_im = rdata[2*AccW-1:AccW];
  assign rd_cnt = (rd_b_q < BaseW'(NumBaselines)) ? frames_q[rd_b_q] : '0;
  always_comb begin
    req_re.start    = (state_q == SRdData);
    req_re.dividend = acc_re[AccW-1] ? AccW'(-acc_re) : acc_re;
    req_re.divisor  = rd_cnt;
    req_im.start    = (state_q == SRdData);
    req_im.dividend = acc_im[AccW-1] ? AccW'(-acc_im) : acc_im;
    req_im.divisor  = rd_cnt;
  end

  cca_div u_div_re (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_re),
    .sts_o  (sts_re),
    .quot_o (quot_re)
  );

  cca_div u_div_im (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_im),
    .sts_o  (sts_im),
    .quot_o (quot_im)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ants_q  <= CfgAntW'(2);
      chans_q <= CfgChanW'(MaxChannels);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgAntennas) ants_q <= cfg_wdata_i[CfgAntW-1:0];
      if (cfg_idx_i == CfgChannels) chans_q <= cfg_wdata_i[CfgChanW-1:0];
    end
  end

  // sequencer, flags, frame counts and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SSweep;
      sweep_q   <= '0;
      flags_q   <= '0;
      for (int i = 0; i < NumBaselines; i++) frames_q[i] <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      out_o.valid <= 1'b0;
    end else begin
      s1_v_q <= op_v;
      s2_v_q <= s1_v_q;
      if (out_o.valid && out_o.ready && !((state_q == SRdOut) && out_free)) begin
        out_o.valid <= 1'b0;
      end
      case (state_q)
        SSweep: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == AddrW'(AccDepth - 1)) state_q <= SIdle;
        end
        SIdle: begin
          if (accept) begin
            case (in_i.cmd)
              CmdLoad: begin
                if (({1'b0, in_i.antenna} < na) &&
                    ({1'b0, in_i.channel} < nc)) begin
                  flags_q[in_i.antenna] <= in_i.ant_ok;
                  if (in_i.ant_ok && (in_i.antenna != '0)) state_q <= SMac;
                end
              end
              CmdRead:  state_q <= SRdAddr;
              CmdClear: begin
                flags_q <= '0;
                for (int i = 0; i < NumBaselines; i++) frames_q[i] <= '0;
                sweep_q <= '0;
                state_q <= SSweep;
              end
              default: ;
            endcase
          end
        end
        SMac: begin
          // count a frame once per valid baseline on the closing channel
          if (op_v && (p_q == '0) && last_ch_q && (frames_q[mac_b] != CountMax)) begin
            frames_q[mac_b] <= frames_q[mac_b] + 1'b1;
          end
          if ((p_q == ProdW'(NumProducts - 1)) && (j_q == k_q - 1'b1)) state_q <= SIdle;
        end
        SRdAddr: state_q <= SRdData;
        SRdData: state_q <= SRdDiv;
        SRdDiv:  if (sts_re.done) state_q <= SRdOut;
        SRdOut: begin
          if (out_free) begin
            out_o.valid <= 1'b1;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      k_q       <= in_i.antenna;
      ch_q      <= in_i.channel;
      last_ch_q <= ({1'b0, in_i.channel} == nc - 1'b1);
      j_q       <= '0;
      p_q       <= '0;
      rd_b_q    <= in_i.baseline;
      rd_p_q    <= in_i.product;
      rd_ch_q   <= in_i.channel;
      cur_q[0]  <= in_i.pol_a_re;
      cur_q[1]  <= in_i.pol_a_im;
      cur_q[2]  <= in_i.pol_b_re;
      cur_q[3]  <= in_i.pol_b_im;
      if ((in_i.cmd == CmdLoad) && ({1'b0, in_i.antenna} < na) &&
          ({1'b0, in_i.channel} < nc)) begin
        samp_q[in_i.antenna][0] <= in_i.pol_a_re;
        samp_q[in_i.antenna][1] <= in_i.pol_a_im;
        samp_q[in_i.antenna][2] <= in_i.pol_b_re;
        samp_q[in_i.antenna][3] <= in_i.pol_b_im;
      end
    end else if (state_q == SMac) begin
      // advance product, then lower antenna
      p_q <= p_q + 1'b1;
      if (p_q == ProdW'(NumProducts - 1)) j_q <= j_q + 1'b1;
    end
    // stage 1: operands for X_j,l times conj(X_k,m)
    s1_addr_q <= raddr;
    s1_ar_q   <= samp_q[j_q][{p_q[1], 1'b0}];
    s1_ai_q   <= samp_q[j_q][{p_q[1], 1'b1}];
    s1_cr_q   <= cur_q[{p_q[0], 1'b0}];
    s1_ci_q   <= cur_q[{p_q[0], 1'b1}];
    // stage 2: partial products and old accumulator value
    s2_addr_q <= s1_addr_q;
    s2_rr_q   <= s1_ar_q * s1_cr_q;
    s2_ii_q   <= s1_ai_q * s1_ci_q;
    s2_ir_q   <= s1_ai_q * s1_cr_q;
    s2_ri_q   <= s1_ar_q * s1_ci_q;
    s2_rd_q   <= rdata;
    // read path: remember signs and count
    if (state_q == SRdData) begin
      neg_re_q <= acc_re[AccW-1];
      neg_im_q <= acc_im[AccW-1];
      zero_q   <= (rd_cnt == '0);
      cnt_q    <= rd_cnt;
    end
    if ((state_q == SRdOut) && out_free) begin
      out_o.vis_re      <= zero_q ? '0 : to_vis(neg_re_q, quot_re);
      out_o.vis_im      <= zero_q ? '0 : to_vis(neg_im_q, quot_im);
      out_o.frame_count <= cnt_q;
    end
  end

  // checks
  a_s2_follows_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> $past(s1_v_q))
    else $error("accumulator write without an issued read");

  a_s1_from_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> $past(state_q == SMac))
    else $error("accumulator operation outside the load sequence");

  a_frames_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SMac) |=> (frames_q[0] >= $past(frames_q[0])))
    else $error("frame count fell during accumulation");

  a_div_done_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_re.done |-> (state_q == SRdDiv) && sts_im.done)
    else $error("divider finished outside a read");

endmodule

`default_nettype wire

### design/cca_acc_ram.sv
// cca_acc_ram: accumulator store, real and imaginary halves side by side.
// One write port, one read port with registered read data. Uses cca_pkg.
`default_nettype none

module cca_acc_ram import cca_pkg::*; (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  logic [2*AccW-1:0]     wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output logic [2*AccW-1:0]     rdata_o
);

  logic [2*AccW-1:0] mem_q [AccDepth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/cca_div.sv
// cca_div: unsigned restoring divider, one quotient bit per cycle.
// Divides a 48-bit magnitude by a 16-bit count. Uses cca_pkg.
`default_nettype none

module cca_div import cca_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output div_sts_t         sts_o,
  output logic [AccW-1:0]  quot_o
);

  localparam int CntW = $clog2(AccW + 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [AccW-1:0]   quo_q, quo_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] dvs_q, dvs_d;
  logic [CountW:0]   rem_sh;
  logic              fits;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, quo_q[AccW-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? CountW'(rem_sh - {1'b0, dvs_q}) : rem_sh[CountW-1:0];
      quo_d = {quo_q[AccW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(AccW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = quo_q;

endmodule

`default_nettype wire
